[rtl/core/vmc_pkg.sv]
// Package for the Vietnamese mark composer: record type, mark codes,
// merge and tone tables. No dependencies.
package vmc_pkg;

  localparam int CpW = 21;

  // diacritic codes
  localparam logic [1:0] DIAC_NONE   = 2'd0;
  localparam logic [1:0] DIAC_CIRC   = 2'd1;
  localparam logic [1:0] DIAC_BREVE  = 2'd2;
  localparam logic [1:0] DIAC_HORN   = 2'd3;

  // tone codes
  localparam logic [2:0] TONE_NONE   = 3'd0;
  localparam logic [2:0] TONE_GRAVE  = 3'd1;
  localparam logic [2:0] TONE_ACUTE  = 3'd2;
  localparam logic [2:0] TONE_HOOK   = 3'd3;
  localparam logic [2:0] TONE_TILDE  = 3'd4;
  localparam logic [2:0] TONE_DOT    = 3'd5;

  localparam logic [CpW-1:0] CP_CIRC  = 21'h00302;
  localparam logic [CpW-1:0] CP_BREVE = 21'h00306;
  localparam logic [CpW-1:0] CP_HORN  = 21'h0031B;
  localparam logic [CpW-1:0] CP_GRAVE = 21'h00300;
  localparam logic [CpW-1:0] CP_ACUTE = 21'h00301;
  localparam logic [CpW-1:0] CP_HOOK  = 21'h00309;
  localparam logic [CpW-1:0] CP_TILDE = 21'h00303;
  localparam logic [CpW-1:0] CP_DOT   = 21'h00323;

  // One queue word: the flushed group (a) and a lone base flushed by end of text (b)
  typedef struct packed {
    logic           a_valid;
    logic [CpW-1:0] a_base;
    logic [1:0]     a_diac;
    logic [2:0]     a_tone;
    logic           b_valid;
    logic [CpW-1:0] b_base;
  } vmc_rec_t;

  localparam int MergeN = 12;
  localparam int RomRows = 24;

  localparam logic [CpW-1:0] MERGE_BASE [MergeN] = '{
    21'h061, 21'h061, 21'h065, 21'h06F, 21'h06F, 21'h075,
    21'h041, 21'h041, 21'h045, 21'h04F, 21'h04F, 21'h055};
  localparam logic [1:0] MERGE_DIAC [MergeN] = '{
    DIAC_CIRC, DIAC_BREVE, DIAC_CIRC, DIAC_CIRC, DIAC_HORN, DIAC_HORN,
    DIAC_CIRC, DIAC_BREVE, DIAC_CIRC, DIAC_CIRC, DIAC_HORN, DIAC_HORN};
  localparam logic [CpW-1:0] MERGE_OUT [MergeN] = '{
    21'h0E2, 21'h103, 21'h0EA, 21'h0F4, 21'h1A1, 21'h1B0,
    21'h0C2, 21'h102, 21'h0CA, 21'h0D4, 21'h1A0, 21'h1AF};

  // column 0 is the untoned letter, columns 1..5 follow the tone codes
  localparam logic [CpW-1:0] TONE_ROM [RomRows][6] = '{
    '{21'h0061, 21'h00E0, 21'h00E1, 21'h1EA3, 21'h00E3, 21'h1EA1},
    '{21'h0103, 21'h1EB1, 21'h1EAF, 21'h1EB3, 21'h1EB5, 21'h1EB7},
    '{21'h00E2, 21'h1EA7, 21'h1EA5, 21'h1EA9, 21'h1EAB, 21'h1EAD},
    '{21'h0065, 21'h00E8, 21'h00E9, 21'h1EBB, 21'h1EBD, 21'h1EB9},
    '{21'h00EA, 21'h1EC1, 21'h1EBF, 21'h1EC3, 21'h1EC5, 21'h1EC7},
    '{21'h0069, 21'h00EC, 21'h00ED, 21'h1EC9, 21'h0129, 21'h1ECB},
    '{21'h006F, 21'h00F2, 21'h00F3, 21'h1ECF, 21'h00F5, 21'h1ECD},
    '{21'h00F4, 21'h1ED3, 21'h1ED1, 21'h1ED5, 21'h1ED7, 21'h1ED9},
    '{21'h01A1, 21'h1EDD, 21'h1EDB, 21'h1EDF, 21'h1EE1, 21'h1EE3},
    '{21'h0075, 21'h00F9, 21'h00FA, 21'h1EE7, 21'h0169, 21'h1EE5},
    '{21'h01B0, 21'h1EEB, 21'h1EE9, 21'h1EED, 21'h1EEF, 21'h1EF1},
    '{21'h0079, 21'h1EF3, 21'h00FD, 21'h1EF7, 21'h1EF9, 21'h1EF5},
    '{21'h0041, 21'h00C0, 21'h00C1, 21'h1EA2, 21'h00C3, 21'h1EA0},
    '{21'h0102, 21'h1EB0, 21'h1EAE, 21'h1EB2, 21'h1EB4, 21'h1EB6},
    '{21'h00C2, 21'h1EA6, 21'h1EA4, 21'h1EA8, 21'h1EAA, 21'h1EAC},
    '{21'h0045, 21'h00C8, 21'h00C9, 21'h1EBA, 21'h1EBC, 21'h1EB8},
    '{21'h00CA, 21'h1EC0, 21'h1EBE, 21'h1EC2, 21'h1EC4, 21'h1EC6},
    '{21'h0049, 21'h00CC, 21'h00CD, 21'h1EC8, 21'h0128, 21'h1ECA},
    '{21'h004F, 21'h00D2, 21'h00D3, 21'h1ECE, 21'h00D5, 21'h1ECC},
    '{21'h00D4, 21'h1ED2, 21'h1ED0, 21'h1ED4, 21'h1ED6, 21'h1ED8},
    '{21'h01A0, 21'h1EDC, 21'h1EDA, 21'h1EDE, 21'h1EE0, 21'h1EE2},
    '{21'h0055, 21'h00D9, 21'h00DA, 21'h1EE6, 21'h0168, 21'h1EE4},
    '{21'h01AF, 21'h1EEA, 21'h1EE8, 21'h1EEC, 21'h1EEE, 21'h1EF0},
    '{21'h0059, 21'h1EF2, 21'h00DD, 21'h1EF6, 21'h1EF8, 21'h1EF4}};

  function automatic logic [1:0] diac_code(input logic [CpW-1:0] cp);
    logic [1:0] d;
    d = DIAC_NONE;
    case (cp)
      CP_CIRC:  d = DIAC_CIRC;
      CP_BREVE: d = DIAC_BREVE;
      CP_HORN:  d = DIAC_HORN;
      default:  d = DIAC_NONE;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] tone_code(input logic [CpW-1:0] cp);
    logic [2:0] t;
    t = TONE_NONE;
    case (cp)
      CP_GRAVE: t = TONE_GRAVE;
      CP_ACUTE: t = TONE_ACUTE;
      CP_HOOK:  t = TONE_HOOK;
      CP_TILDE: t = TONE_TILDE;
      CP_DOT:   t = TONE_DOT;
      default:  t = TONE_NONE;
    endcase
    return t;
  endfunction

  function automatic logic [CpW-1:0] diac_cp(input logic [1:0] d);
    logic [CpW-1:0] cp;
    cp = '0;
    case (d)
      DIAC_CIRC:  cp = CP_CIRC;
      DIAC_BREVE: cp = CP_BREVE;
      DIAC_HORN:  cp = CP_HORN;
      default:    cp = '0;
    endcase
    return cp;
  endfunction

  function automatic logic [CpW-1:0] tone_cp(input logic [2:0] t);
    logic [CpW-1:0] cp;
    cp = '0;
    case (t)
      TONE_GRAVE: cp = CP_GRAVE;
      TONE_ACUTE: cp = CP_ACUTE;
      TONE_HOOK:  cp = CP_HOOK;
      TONE_TILDE: cp = CP_TILDE;
      TONE_DOT:   cp = CP_DOT;
      default:    cp = '0;
    endcase
    return cp;
  endfunction

endpackage

[rtl/core/vmc_front.sv]
// Front end: takes code points, collects marks onto the pending base and
// pushes one queue word per item that flushes anything. Uses vmc_pkg.
module vmc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vmc_pkg::CpW-1:0]        in_cp,
  input  logic                           in_eot,
  output logic                           push,
  output vmc_pkg::vmc_rec_t              push_rec,
  input  logic                           q_full
);

  logic [vmc_pkg::CpW-1:0] pending_base, pending_base_next;
  logic                    base_valid, base_valid_next;
  logic [1:0]              pending_diacritic, pending_diacritic_next;
  logic [2:0]              pending_tone, pending_tone_next;

  logic       accept;
  logic [1:0] d;
  logic [2:0] t;
  logic       is_mark;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign d        = vmc_pkg::diac_code(in_cp);
  assign t        = vmc_pkg::tone_code(in_cp);
  assign is_mark  = base_valid && ((d != vmc_pkg::DIAC_NONE) || (t != vmc_pkg::TONE_NONE));

  always_comb begin
    pending_base_next      = pending_base;
    base_valid_next        = base_valid;
    pending_diacritic_next = pending_diacritic;
    pending_tone_next      = pending_tone;
    push_rec               = '0;

    if (is_mark) begin
      if (d != vmc_pkg::DIAC_NONE) begin
        pending_diacritic_next = d;
      end else begin
        pending_tone_next = t;
      end
      // end of text flushes the updated group
      if (in_eot) begin
        push_rec.a_valid = 1'b1;
        push_rec.a_base  = pending_base;
        push_rec.a_diac  = pending_diacritic_next;
        push_rec.a_tone  = pending_tone_next;
      end
    end else begin
      push_rec.a_valid       = base_valid;
      push_rec.a_base        = pending_base;
      push_rec.a_diac        = pending_diacritic;
      push_rec.a_tone        = pending_tone;
      push_rec.b_valid       = in_eot;
      push_rec.b_base        = in_cp;
      pending_base_next      = in_cp;
      base_valid_next        = 1'b1;
      pending_diacritic_next = vmc_pkg::DIAC_NONE;
      pending_tone_next      = vmc_pkg::TONE_NONE;
    end

    if (in_eot) begin
      pending_base_next      = '0;
      base_valid_next        = 1'b0;
      pending_diacritic_next = vmc_pkg::DIAC_NONE;
      pending_tone_next      = vmc_pkg::TONE_NONE;
    end
  end

  assign push = accept && (push_rec.a_valid || push_rec.b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_base      <= '0;
      base_valid        <= 1'b0;
      pending_diacritic <= vmc_pkg::DIAC_NONE;
      pending_tone      <= vmc_pkg::TONE_NONE;
    end else if (accept) begin
      pending_base      <= pending_base_next;
      base_valid        <= base_valid_next;
      pending_diacritic <= pending_diacritic_next;
      pending_tone      <= pending_tone_next;
    end
  end

endmodule

[rtl/core/vmc_queue.sv]
// Short register queue of flushed groups between front and back end.
// Uses vmc_pkg for the word type.
module vmc_queue #(
  parameter int Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vmc_pkg::vmc_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output vmc_pkg::vmc_rec_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  vmc_pkg::vmc_rec_t store [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/vmc_back.sv]
// Back end: composes the queued group (merge, then tone lookup) and plays out its
// code points one word a cycle while out_ready is high, from a shifting burst register. Uses vmc_pkg.
module vmc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  vmc_pkg::vmc_rec_t       head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [vmc_pkg::CpW-1:0] out_cp,
  output logic                    out_last
);

  logic [vmc_pkg::CpW-1:0] slot [4];
  logic [vmc_pkg::CpW-1:0] new_slot [4];
  logic [2:0]              cnt, new_cnt;

  logic [vmc_pkg::CpW-1:0] merged, toned;
  logic [1:0]              d_left;
  logic [2:0]              t_left;
  logic                    taken, load;

  // merge diacritic into base, then tone via the ROM
  always_comb begin
    merged = head.a_base;
    d_left = head.a_diac;
    for (int k = 0; k < vmc_pkg::MergeN; k++) begin
      if (head.a_diac != vmc_pkg::DIAC_NONE && head.a_base == vmc_pkg::MERGE_BASE[k]
          && head.a_diac == vmc_pkg::MERGE_DIAC[k]) begin
        merged = vmc_pkg::MERGE_OUT[k];
        d_left = vmc_pkg::DIAC_NONE;
      end
    end
    toned  = merged;
    t_left = head.a_tone;
    if (head.a_tone >= vmc_pkg::TONE_GRAVE && head.a_tone <= vmc_pkg::TONE_DOT) begin
      for (int k = 0; k < vmc_pkg::RomRows; k++) begin
        if (merged == vmc_pkg::TONE_ROM[k][0]) begin
          toned  = vmc_pkg::TONE_ROM[k][head.a_tone];
          t_left = vmc_pkg::TONE_NONE;
        end
      end
    end else begin
      t_left = vmc_pkg::TONE_NONE;
    end
  end

  // pack the words of this record without gaps
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      new_slot[i] = '0;
    end
    new_cnt = 3'd0;
    if (head.a_valid) begin
      new_slot[new_cnt[1:0]] = toned;
      new_cnt = new_cnt + 3'd1;
      if (t_left != vmc_pkg::TONE_NONE) begin
        new_slot[new_cnt[1:0]] = vmc_pkg::tone_cp(t_left);
        new_cnt = new_cnt + 3'd1;
      end
      if (d_left != vmc_pkg::DIAC_NONE) begin
        new_slot[new_cnt[1:0]] = vmc_pkg::diac_cp(d_left);
        new_cnt = new_cnt + 3'd1;
      end
    end
    if (head.b_valid) begin
      new_slot[new_cnt[1:0]] = head.b_base;
      new_cnt = new_cnt + 3'd1;
    end
  end

  assign out_valid = (cnt != 3'd0);
  assign out_last  = (cnt == 3'd1);
  assign out_cp    = slot[0];
  assign taken     = out_valid && out_ready;
  assign load      = !q_empty && ((cnt == 3'd0) || (cnt == 3'd1 && taken));
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= new_slot;
    end else if (taken) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
      slot[2] <= slot[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= new_cnt;
    end else if (taken) begin
      cnt <= cnt - 3'd1;
    end
  end

endmodule

[rtl/core/vietnamese_mark_composer.sv]
// Vietnamese mark composer, top level: front end, group queue, back end.
// Path: an item's results pass the queue register, then the back end's burst register.
// Throughput: one item a cycle in while the queue is not full; one result word a
// cycle out while m_axis_tready is high, from a burst register of up to four words.
// Reset (rst, synchronous): clears pending group, queue and output; no clearing pass.
module vietnamese_mark_composer #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [20:0] code_point, [23:21] zero
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [20:0] out_code_point, [23:21] zero
  output logic        m_axis_tlast   // last_of_run
);

  vmc_pkg::vmc_rec_t       push_rec, head;
  logic                    push, pop, q_full, q_empty;
  logic [vmc_pkg::CpW-1:0] out_cp;

  vmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cp    (s_axis_tdata[vmc_pkg::CpW-1:0]),
    .in_eot   (s_axis_tlast),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  vmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  vmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_cp    (out_cp),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_cp};

endmodule
